// File: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes for the shape set table
// Request and result layouts, opcode and status codes, and the token that
// walks the row of table cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int COUNT_W         = 5;
	localparam int VALUE_W         = 32;

	localparam logic [2:0] OP_INSERT     = 3'd0;
	localparam logic [2:0] OP_SEARCH     = 3'd1;
	localparam logic [2:0] OP_REMOVE     = 3'd2;
	localparam logic [2:0] OP_DROP_RECTS = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	localparam logic [2:0] STATUS_DONE     = 3'd0;
	localparam logic [2:0] STATUS_PRESENT  = 3'd1;
	localparam logic [2:0] STATUS_MISSING  = 3'd2;
	localparam logic [2:0] STATUS_FULL     = 3'd3;
	localparam logic [2:0] STATUS_NEGATIVE = 3'd4;

	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_RECT   = 1'b1;

	typedef struct packed {
		logic [2:0]                opcode;
		logic                      shape_kind;
		logic signed [VALUE_W-1:0] first_value;
		logic signed [VALUE_W-1:0] second_value;
		logic signed [VALUE_W-1:0] third_value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               found;
		logic [COUNT_W-1:0] circle_count;
		logic [COUNT_W-1:0] rectangle_count;
	} rsp_t;

	// What each cell does with a passing token
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_PROBE,
		ACT_REMOVE,
		ACT_DROP,
		ACT_CLEAR,
		ACT_WRITE
	} act_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_WALK
	} fsm_t;

	typedef struct packed {
		logic               valid;
		act_t               act;
		logic [2:0]         op;
		logic               kind;
		logic               neg;
		logic [VALUE_W-1:0] first;
		logic [VALUE_W-1:0] second;
		logic [VALUE_W-1:0] third;
		logic               hit;
		logic               free_seen;
		logic               wrote;
		logic [COUNT_W-1:0] ncirc;
		logic [COUNT_W-1:0] nrect;
	} token_t;

endpackage

`default_nettype wire

// File: design/shape_set_table.sv
// Timing: a request walks the row of TABLE_DEPTH cells one cell per cycle;
// done is registered from the token at the end of the row. An insert that stores
// a record walks the row twice (the second walk writes the first free slot).
// Requests: a new one is accepted only while idle, and busy is high until done.
// The receiver cannot stall; done is one cycle.
// Reset: arst_n empties the table and aborts any request in flight.
// ----------------------------------------------------------------------------
// shape_set_table: deduplicating table of circle and rectangle records
// Insert, search, remove, remove all rectangles and clear, each reporting
// a status and the circle and rectangle counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shape_set_table #(
	parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire sst_pkg::req_t request,
	output logic               busy,
	output logic               done,
	output sst_pkg::rsp_t      result
);

	sst_pkg::token_t tok [TABLE_DEPTH+1];
	sst_pkg::token_t tail;
	sst_pkg::token_t inject;
	sst_pkg::token_t fresh;
	sst_pkg::fsm_t   state_q;
	sst_pkg::fsm_t   state_d;
	sst_pkg::rsp_t   result_d;
	sst_pkg::rsp_t   result_q;
	logic            done_q;
	logic            done_d;
	logic            accept;
	logic            reinject;
	logic            neg;
	logic            lookup_op;

	assign accept = start && (state_q == sst_pkg::FSM_IDLE);
	assign busy   = (state_q == sst_pkg::FSM_WALK);
	assign tail   = tok[TABLE_DEPTH];

	assign neg = (request.shape_kind == sst_pkg::KIND_RECT) ?
		(request.first_value[sst_pkg::VALUE_W-1] | request.second_value[sst_pkg::VALUE_W-1]) :
		request.third_value[sst_pkg::VALUE_W-1];

	assign lookup_op = (request.opcode == sst_pkg::OP_INSERT) ||
		(request.opcode == sst_pkg::OP_SEARCH) || (request.opcode == sst_pkg::OP_REMOVE);

	// Build the token for a fresh request
	always_comb begin
		fresh           = '0;
		fresh.valid     = 1'b1;
		fresh.op        = request.opcode;
		fresh.kind      = request.shape_kind;
		fresh.neg       = neg && lookup_op;
		fresh.first     = request.first_value;
		fresh.second    = request.second_value;
		fresh.third     = (request.shape_kind == sst_pkg::KIND_RECT) ? '0 : request.third_value;
		case (request.opcode)
			sst_pkg::OP_INSERT, sst_pkg::OP_SEARCH:
				fresh.act = neg ? sst_pkg::ACT_NONE : sst_pkg::ACT_PROBE;
			sst_pkg::OP_REMOVE:
				fresh.act = neg ? sst_pkg::ACT_NONE : sst_pkg::ACT_REMOVE;
			sst_pkg::OP_DROP_RECTS:
				fresh.act = sst_pkg::ACT_DROP;
			sst_pkg::OP_CLEAR:
				fresh.act = sst_pkg::ACT_CLEAR;
			default:
				fresh.act = sst_pkg::ACT_NONE;
		endcase
	end

	// A new record with a free slot goes around again to be written
	assign reinject = tail.valid && (tail.act == sst_pkg::ACT_PROBE) &&
		(tail.op == sst_pkg::OP_INSERT) && !tail.hit && tail.free_seen;

	always_comb begin
		inject = tail;
		if (accept) begin
			inject = fresh;
		end else if (reinject) begin
			inject.act   = sst_pkg::ACT_WRITE;
			inject.wrote = 1'b0;
			inject.ncirc = '0;
			inject.nrect = '0;
		end else begin
			inject.valid = 1'b0;
		end
	end

	assign tok[0] = inject;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		sst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	always_comb begin
		state_d                  = state_q;
		done_d                   = 1'b0;
		result_d                 = result_q;
		result_d.status          = sst_pkg::STATUS_DONE;
		result_d.found           = 1'b0;
		result_d.circle_count    = tail.ncirc;
		result_d.rectangle_count = tail.nrect;
		case (tail.op)
			sst_pkg::OP_INSERT: begin
				if (tail.neg) begin
					result_d.status = sst_pkg::STATUS_NEGATIVE;
				end else if (tail.hit) begin
					result_d.status = sst_pkg::STATUS_PRESENT;
				end else if (!tail.free_seen) begin
					result_d.status = sst_pkg::STATUS_FULL;
				end
			end
			sst_pkg::OP_SEARCH: begin
				if (tail.neg) begin
					result_d.status = sst_pkg::STATUS_NEGATIVE;
				end else if (tail.hit) begin
					result_d.found = 1'b1;
				end else begin
					result_d.status = sst_pkg::STATUS_MISSING;
				end
			end
			sst_pkg::OP_REMOVE: begin
				if (tail.neg) begin
					result_d.status = sst_pkg::STATUS_NEGATIVE;
				end else if (!tail.hit) begin
					result_d.status = sst_pkg::STATUS_MISSING;
				end
			end
			default: begin
			end
		endcase
		case (state_q)
			sst_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = sst_pkg::FSM_WALK;
				end
			end
			sst_pkg::FSM_WALK: begin
				if (tail.valid && !reinject) begin
					done_d  = 1'b1;
					state_d = sst_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = sst_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sst_pkg::FSM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: design/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell: one slot of the shape set table
// Holds one record, applies the passing token's action to it, adds its
// match, free slot and count information, and hands the token on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sst_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sst_pkg::token_t tok_in,
	output sst_pkg::token_t     tok_out
);

	logic                        valid_q;
	logic                        kind_q;
	logic [sst_pkg::VALUE_W-1:0] first_q;
	logic [sst_pkg::VALUE_W-1:0] second_q;
	logic [sst_pkg::VALUE_W-1:0] third_q;

	sst_pkg::token_t tok_d;
	sst_pkg::token_t tok_q;
	logic            valid_d;
	logic            wr;
	logic            match;
	logic            kind_after;

	assign match = valid_q && (kind_q == tok_in.kind) &&
		(first_q == tok_in.first) && (second_q == tok_in.second) &&
		((tok_in.kind == sst_pkg::KIND_RECT) || (third_q == tok_in.third));

	always_comb begin
		tok_d   = tok_in;
		valid_d = valid_q;
		wr      = 1'b0;
		if (tok_in.valid) begin
			case (tok_in.act)
				sst_pkg::ACT_PROBE: begin
					tok_d.hit       = tok_in.hit | match;
					tok_d.free_seen = tok_in.free_seen | ~valid_q;
				end
				sst_pkg::ACT_REMOVE: begin
					if (match) begin
						valid_d = 1'b0;
					end
					tok_d.hit = tok_in.hit | match;
				end
				sst_pkg::ACT_DROP: begin
					if (valid_q && (kind_q == sst_pkg::KIND_RECT)) begin
						valid_d = 1'b0;
					end
				end
				sst_pkg::ACT_CLEAR: begin
					valid_d = 1'b0;
				end
				sst_pkg::ACT_WRITE: begin
					// take the record in the first free slot only
					if (!valid_q && !tok_in.wrote) begin
						wr      = 1'b1;
						valid_d = 1'b1;
					end
					tok_d.wrote = tok_in.wrote | ~valid_q;
				end
				default: begin
				end
			endcase
		end
		kind_after = wr ? tok_in.kind : kind_q;
		if (valid_d) begin
			if (kind_after == sst_pkg::KIND_RECT) begin
				tok_d.nrect = tok_in.nrect + sst_pkg::COUNT_W'(1);
			end else begin
				tok_d.ncirc = tok_in.ncirc + sst_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			if (tok_in.valid) begin
				valid_q <= valid_d;
			end
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			kind_q   <= tok_in.kind;
			first_q  <= tok_in.first;
			second_q <= tok_in.second;
			third_q  <= tok_in.third;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: design/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker: port-level checks for the shape set table
// Watches the request and result handshake of the top level over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sst_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire sst_pkg::req_t request,
	input wire logic          busy,
	input wire logic          done,
	input wire sst_pkg::rsp_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("request finished without a result");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (result.status == sst_pkg::STATUS_DONE))
		else $error("search hit with an error status");

endmodule

bind shape_set_table sst_checker u_sst_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.request (request),
	.busy    (busy),
	.done    (done),
	.result  (result)
);

`default_nettype wire
